[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tape machine token executor.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[design/tmte_pkg.sv]
// ----------------------------------------------------------------------------
// tmte_pkg
// Types, codes and widths shared by the tape machine token executor.
// ----------------------------------------------------------------------------
package tmte_pkg;

   localparam int TAPE_CELLS_DEF = 32768;
   localparam int NEST_LIMIT_DEF = 64;
   localparam int PROG_DEPTH     = 4096;

   localparam int CMD_W      = 3;
   localparam int AMT_W      = 16;
   localparam int IDX_W      = $clog2(PROG_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int LEN_CFG_W  = 16;

   localparam int REQ_USER_W   = CMD_W;
   localparam int REQ_FIELDS_W = AMT_W + IDX_W + BYTE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 1;
   localparam int RSP_FIELDS_W = IDX_W + STATUS_W + BYTE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [LEN_CFG_W-1:0] TAPE_LENGTH_RESET = 16'd32768;
   localparam logic                 IO_ENABLE_RESET   = 1'b1;

   // register index, taken from the word address
   localparam logic CSR_IDX_TAPE_LENGTH = 1'b0;
   localparam logic CSR_IDX_IO_ENABLE   = 1'b1;

   localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ARITH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_END   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PRINT = 3'd5;
   localparam logic [CMD_W-1:0] CMD_INPUT = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OFF_TAPE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NESTED    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ARITH,
      OP_MOVE,
      OP_BEGIN,
      OP_END,
      OP_PRINT,
      OP_INPUT
   } op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_FETCH,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic signed [AMT_W-1:0]  amount;
      logic [IDX_W-1:0]         token_index;
      logic [BYTE_W-1:0]        input_byte;
   } item_type;

endpackage

[design/tape_machine_token_executor.sv]
// ----------------------------------------------------------------------------
// tape_machine_token_executor
// Run-length tape machine core: executes one token per request transfer
// against a byte tape, a cell pointer and a loop-start stack.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: one token per transfer (command, amount,
//   token_index, input_byte). Response channel rsp_*: exactly one result
//   per token, in order (next_index, status, print_valid, print_byte).
//   Registers on csr_*: tape_length at byte address 0, io_enable at 4;
//   write them only while no token is in flight.
//   Path: each token passes the queue, the fetch register and the result
//   register behind rsp_tvalid. Executor: one token at a time, reading the
//   current tape cell from synchronous RAM in the fetch state and writing it
//   back in execute. A two-entry queue lets requests keep arriving meanwhile.
//   Reset: the tape is cleared one cell per cycle, all TAPE_CELLS cells, with
//   req_tready low; pointer and loop depth start at zero.
//   Stall: when rsp_tready is low the result holds, the executor stops and
//   the queue fills, after which req_tready drops.
// ----------------------------------------------------------------------------
module tape_machine_token_executor #(
   parameter int TAPE_CELLS = tmte_pkg::TAPE_CELLS_DEF,
   parameter int NEST_LIMIT = tmte_pkg::NEST_LIMIT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, lowest bit up: amount[15:0], token_index[27:16],
   // input_byte[35:28], zero pad
   input  logic [tmte_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser, lowest bit up: command[2:0]
   input  logic [tmte_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata, lowest bit up: next_index[11:0], status[13:12],
   // print_byte[21:14], zero pad
   output logic [tmte_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tuser, lowest bit up: print_valid[0]
   output logic [tmte_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tmte_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tmte_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tmte_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   import tmte_pkg::*;

   localparam int LEN_W = $clog2(TAPE_CELLS + 1);

   logic              io_enable;
   logic [LEN_W-1:0]  eff_len;
   logic              tape_clearing;
   logic              push_valid;
   logic              push_ready;
   item_type          push_item;
   logic              pop_valid;
   logic              pop_ready;
   item_type          pop_item;
   logic [IDX_W-1:0]  next_index;
   logic [STATUS_W-1:0] status;
   logic              print_valid;
   logic [BYTE_W-1:0] print_byte;

   tmte_csr #(
      .TAPE_CELLS (TAPE_CELLS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .io_enable   (io_enable),
      .eff_len     (eff_len)
   );

   tmte_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .io_enable     (io_enable),
      .tape_clearing (tape_clearing),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   tmte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tmte_back #(
      .TAPE_CELLS (TAPE_CELLS),
      .NEST_LIMIT (NEST_LIMIT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .eff_len         (eff_len),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .tape_clearing   (tape_clearing),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_next_index  (next_index),
      .rsp_status      (status),
      .rsp_print_valid (print_valid),
      .rsp_print_byte  (print_byte)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}},
                       print_byte, status, next_index};
   assign rsp_tuser = print_valid;

endmodule

[design/tmte_ram.sv]
// ----------------------------------------------------------------------------
// tmte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tmte_csr.sv]
// ----------------------------------------------------------------------------
// tmte_csr
// Configuration registers behind the APB-style port; also keeps the clamped
// tape length used by the move range check.
// ----------------------------------------------------------------------------
module tmte_csr #(
   parameter int TAPE_CELLS = tmte_pkg::TAPE_CELLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tmte_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tmte_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tmte_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic                                 io_enable,
   output logic [$clog2(TAPE_CELLS+1)-1:0]      eff_len
);

   import tmte_pkg::*;

   localparam int LEN_W = $clog2(TAPE_CELLS + 1);

   logic [LEN_CFG_W-1:0] tape_length_ff, tape_length_in;
   logic                 io_enable_ff, io_enable_in;
   logic [LEN_W-1:0]     eff_len_ff, eff_len_in;
   logic                 wr_strobe;
   logic                 reg_idx;

   // zero acts as one cell, anything past the tape acts as the whole tape
   function automatic logic [31:0] clamp_len(input logic [LEN_CFG_W-1:0] v);
      logic [31:0] w;
      w = {{(32 - LEN_CFG_W){1'b0}}, v};
      if (w == 32'd0) begin
         return 32'd1;
      end
      if (w > 32'(TAPE_CELLS)) begin
         return 32'(TAPE_CELLS);
      end
      return w;
   endfunction

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1];

   always_comb begin
      tape_length_in = tape_length_ff;
      io_enable_in   = io_enable_ff;
      eff_len_in     = eff_len_ff;
      if (wr_strobe) begin
         unique case (reg_idx)
            CSR_IDX_TAPE_LENGTH: begin
               tape_length_in = csr_pwdata[LEN_CFG_W-1:0];
               eff_len_in     = LEN_W'(clamp_len(csr_pwdata[LEN_CFG_W-1:0]));
            end
            CSR_IDX_IO_ENABLE: begin
               io_enable_in = csr_pwdata[0];
            end
            default: begin
               tape_length_in = tape_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tape_length_ff <= TAPE_LENGTH_RESET;
         io_enable_ff   <= IO_ENABLE_RESET;
         eff_len_ff     <= LEN_W'(clamp_len(TAPE_LENGTH_RESET));
      end else begin
         tape_length_ff <= tape_length_in;
         io_enable_ff   <= io_enable_in;
         eff_len_ff     <= eff_len_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_TAPE_LENGTH: csr_prdata = {{(CSR_DATA_W - LEN_CFG_W){1'b0}}, tape_length_ff};
         CSR_IDX_IO_ENABLE:   csr_prdata = {{(CSR_DATA_W - 1){1'b0}}, io_enable_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign io_enable = io_enable_ff;
   assign eff_len   = eff_len_ff;

endmodule

[design/tmte_front.sv]
// ----------------------------------------------------------------------------
// tmte_front
// Unpacks request transfers and classifies the command into an operation
// before it enters the token queue.
// ----------------------------------------------------------------------------
module tmte_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, lowest bit up: amount[15:0], token_index[27:16],
   // input_byte[35:28], zero pad
   input  logic [tmte_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser, lowest bit up: command[2:0]
   input  logic [tmte_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                 io_enable,
   input  logic                                 tape_clearing,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output tmte_pkg::item_type                   push_item
);

   import tmte_pkg::*;

   logic [CMD_W-1:0] command;
   op_type           op;

   assign command = req_tuser[CMD_W-1:0];

   // print and input collapse to no-ops when io is off
   always_comb begin
      unique case (command)
         CMD_ARITH: op = OP_ARITH;
         CMD_MOVE:  op = OP_MOVE;
         CMD_BEGIN: op = OP_BEGIN;
         CMD_END:   op = OP_END;
         CMD_PRINT: op = io_enable ? OP_PRINT : OP_NONE;
         CMD_INPUT: op = io_enable ? OP_INPUT : OP_NONE;
         default:   op = OP_NONE;
      endcase
   end

   always_comb begin
      push_item.op          = op;
      push_item.amount      = req_tdata[0 +: AMT_W];
      push_item.token_index = req_tdata[AMT_W +: IDX_W];
      push_item.input_byte  = req_tdata[AMT_W + IDX_W +: BYTE_W];
   end

   // hold off requests while the tape is being cleared
   assign req_tready = push_ready && !tape_clearing;
   assign push_valid = req_tvalid && !tape_clearing;

endmodule

[design/tmte_queue.sv]
// ----------------------------------------------------------------------------
// tmte_queue
// Small FIFO of classified tokens between the front end and the executor.
// ----------------------------------------------------------------------------
module tmte_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tmte_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tmte_pkg::item_type pop_item
);

   import tmte_pkg::*;

   localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entries_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/tmte_back.sv]
// ----------------------------------------------------------------------------
// tmte_back
// Token executor: owns the tape, cell pointer and loop stack. Clears the tape
// after reset, then runs each token through a fetch state and an execute state.
// ----------------------------------------------------------------------------
module tmte_back #(
   parameter int TAPE_CELLS = tmte_pkg::TAPE_CELLS_DEF,
   parameter int NEST_LIMIT = tmte_pkg::NEST_LIMIT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [$clog2(TAPE_CELLS+1)-1:0]      eff_len,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  tmte_pkg::item_type                   pop_item,
   output logic                                 tape_clearing,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tmte_pkg::IDX_W-1:0]           rsp_next_index,
   output logic [tmte_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_print_valid,
   output logic [tmte_pkg::BYTE_W-1:0]          rsp_print_byte
);

   import tmte_pkg::*;

   `include "assert_macros.svh"

   localparam int PTR_W  = $clog2(TAPE_CELLS);
   localparam int LEN_W  = $clog2(TAPE_CELLS + 1);
   localparam int SDEPTH = NEST_LIMIT + 1;
   localparam int SA_W   = $clog2(SDEPTH);
   localparam int DEP_W  = $clog2(NEST_LIMIT + 2);
   localparam int SUM_W  = ((PTR_W > AMT_W) ? PTR_W : AMT_W) + 2;

   back_state_type       state_ff, state_in;
   logic [PTR_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [DEP_W-1:0]     depth_ff, depth_in;
   item_type             item_ff, item_in;
   logic                 out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]     next_index_ff, next_index_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 print_valid_ff, print_valid_in;
   logic [BYTE_W-1:0]    print_byte_ff, print_byte_in;

   logic                 tape_wr_en;
   logic [PTR_W-1:0]     tape_wr_addr;
   logic [BYTE_W-1:0]    tape_wr_data;
   logic [BYTE_W-1:0]    tape_rd_data;
   logic                 stack_wr_en;
   logic [SA_W-1:0]      stack_wr_addr;
   logic [SA_W-1:0]      stack_rd_addr;
   logic [IDX_W-1:0]     stack_rd_data;

   logic signed [SUM_W-1:0] move_sum;
   logic                    move_off;
   logic                    fetch_take;

   tmte_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TAPE_CELLS)
   ) u_tape (
      .clock   (clock),
      .wr_en   (tape_wr_en),
      .wr_addr (tape_wr_addr),
      .wr_data (tape_wr_data),
      .rd_addr (ptr_ff),
      .rd_data (tape_rd_data)
   );

   tmte_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SDEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (item_ff.token_index),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   // top of stack; address is a don't-care while the stack is empty
   assign stack_rd_addr = (depth_ff == '0) ? '0 : SA_W'(depth_ff - 1'b1);
   assign stack_wr_addr = depth_ff[SA_W-1:0];

   assign move_sum = $signed({{(SUM_W - PTR_W){1'b0}}, ptr_ff})
                   + $signed({{(SUM_W - AMT_W){item_ff.amount[AMT_W-1]}}, item_ff.amount});
   assign move_off = move_sum[SUM_W-1]
                  || ($unsigned(move_sum) >= {{(SUM_W - LEN_W){1'b0}}, eff_len});

   // the output register is empty or drains this cycle, so execute can load it
   assign fetch_take = pop_valid && (!out_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clear_addr_ff == PTR_W'(TAPE_CELLS - 1)) begin
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            if (fetch_take) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in = BK_FETCH;
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop_ready      = 1'b0;
      tape_wr_en     = 1'b0;
      tape_wr_addr   = ptr_ff;
      tape_wr_data   = tape_rd_data;
      stack_wr_en    = 1'b0;
      clear_addr_in  = clear_addr_ff;
      ptr_in         = ptr_ff;
      depth_in       = depth_ff;
      item_in        = item_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      next_index_in  = next_index_ff;
      status_in      = status_ff;
      print_valid_in = print_valid_ff;
      print_byte_in  = print_byte_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            tape_wr_en    = 1'b1;
            tape_wr_addr  = clear_addr_ff;
            tape_wr_data  = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
         end
         BK_FETCH: begin
            pop_ready = !out_valid_ff || rsp_tready;
            if (fetch_take) begin
               item_in = pop_item;
            end
         end
         BK_EXEC: begin
            out_valid_in   = 1'b1;
            next_index_in  = item_ff.token_index;
            status_in      = ST_OK;
            print_valid_in = 1'b0;
            print_byte_in  = '0;
            unique case (item_ff.op)
               OP_ARITH: begin
                  tape_wr_en   = 1'b1;
                  tape_wr_data = tape_rd_data + item_ff.amount[BYTE_W-1:0];
               end
               OP_MOVE: begin
                  if (move_off) begin
                     status_in = ST_OFF_TAPE;
                  end else begin
                     ptr_in = move_sum[PTR_W-1:0];
                  end
               end
               OP_BEGIN: begin
                  // push while a slot is free; depth saturates when full
                  if (depth_ff < DEP_W'(SDEPTH)) begin
                     stack_wr_en = 1'b1;
                     depth_in    = depth_ff + 1'b1;
                  end
                  if (depth_ff >= DEP_W'(NEST_LIMIT)) begin
                     status_in = ST_NESTED;
                  end
               end
               OP_END: begin
                  if (depth_ff == '0) begin
                     status_in = ST_UNMATCHED;
                  end else if (tape_rd_data != '0) begin
                     next_index_in = stack_rd_data;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                  end
               end
               OP_PRINT: begin
                  print_valid_in = 1'b1;
                  print_byte_in  = tape_rd_data;
               end
               OP_INPUT: begin
                  tape_wr_en   = 1'b1;
                  tape_wr_data = item_ff.input_byte;
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clear_addr_ff <= '0;
         ptr_ff        <= '0;
         depth_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         ptr_ff        <= ptr_in;
         depth_ff      <= depth_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      next_index_ff  <= next_index_in;
      status_ff      <= status_in;
      print_valid_ff <= print_valid_in;
      print_byte_ff  <= print_byte_in;
   end

   assign tape_clearing   = state_ff == BK_CLEAR;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_next_index  = next_index_ff;
   assign rsp_status      = status_ff;
   assign rsp_print_valid = print_valid_ff;
   assign rsp_print_byte  = print_byte_ff;

   `ASSERT_IMPLIES(a_exec_out_free, clock, reset, state_ff == BK_EXEC, !out_valid_ff, "execute found the result register occupied")
   `ASSERT_ALWAYS(a_depth_bound, clock, reset, depth_ff <= DEP_W'(SDEPTH), "loop depth past stack size")
   `ASSERT_ALWAYS(a_ptr_bound, clock, reset, {1'b0, ptr_ff} < (PTR_W + 1)'(TAPE_CELLS), "cell pointer off the tape")
   `ASSERT_IMPLIES(a_no_pop_clear, clock, reset, state_ff == BK_CLEAR, !pop_ready && !rsp_tvalid, "token taken during tape clear")

endmodule
